/* design/spc_pkg.sv */
// ----------------------------------------------------------------------------
// spc_pkg
// Shared types and constants for the scanline priority compositor.
// ----------------------------------------------------------------------------
package spc_pkg;

  // Command codes on cmd_i; the remaining codes are ignored
  typedef enum logic [2:0] {
    CMD_INIT       = 3'd0,
    CMD_PLOT_MAIN  = 3'd1,
    CMD_PLOT_SUB   = 3'd2,
    CMD_SET_WINDOW = 3'd3,
    CMD_EMIT       = 3'd4
  } cmd_e;

  // Configuration register indexes
  typedef enum logic [2:0] {
    CFG_MATH_MASK   = 3'd0,
    CFG_USE_SUB     = 3'd1,
    CFG_SUBTRACT    = 3'd2,
    CFG_HALVE       = 3'd3,
    CFG_FIXED_COLOR = 3'd4,
    CFG_BRIGHTNESS  = 3'd5,
    CFG_HIRES       = 3'd6,
    CFG_DISP_OFF    = 3'd7
  } cfg_idx_e;

  localparam logic [2:0] SRC_BACKDROP = 3'd6;

  typedef struct packed {
    logic [6:0]  math_mask;
    logic        use_sub;
    logic        subtract;
    logic        halve_en;
    logic [14:0] fixed_color;
    logic [3:0]  brightness;
    logic        hires;
    logic        disp_off;
  } cfg_t;

  // One column of a line store
  typedef struct packed {
    logic [2:0]  src;
    logic [3:0]  prio;
    logic [14:0] color;
  } entry_t;

  // One memory word: both line stores plus the window bits of a column
  typedef struct packed {
    entry_t main_px;
    entry_t sub_px;
    logic   win_main;
    logic   win_sub;
  } word_t;

  typedef struct packed {
    logic [14:0] color;
    logic [3:0]  brightness;
    logic        last;
  } result_t;

endpackage

/* design/spc_composite.sv */
// ----------------------------------------------------------------------------
// spc_composite
// Color math for one column: window masking, per-source enable, fixed or
// sub operand, per-channel saturating add/subtract with optional halving.
// ----------------------------------------------------------------------------
module spc_composite (
  input  spc_pkg::cfg_t   cfg_i,
  input  spc_pkg::entry_t main_i,
  input  spc_pkg::entry_t sub_i,
  input  logic            win_main_i,
  input  logic            win_sub_i,
  output logic [14:0]     color_o
);

  logic [7:0]  mask_ext;
  logic [14:0] mc;
  logic [14:0] opnd;
  logic        halve;
  logic        math_on;
  logic [14:0] math_res;
  logic [4:0]  ca [3];
  logic [4:0]  cb [3];
  logic [5:0]  sum [3];
  logic [4:0]  diff [3];

  always_comb begin
    // source seven has no enable bit
    mask_ext = {1'b0, cfg_i.math_mask};
    mc       = win_main_i ? main_i.color : 15'd0;
    math_on  = win_sub_i & mask_ext[main_i.src];
    opnd     = cfg_i.use_sub ? sub_i.color : cfg_i.fixed_color;
    halve    = cfg_i.halve_en & win_main_i &
               (!cfg_i.use_sub || (sub_i.src != spc_pkg::SRC_BACKDROP));
    math_res = '0;
    for (int ch = 0; ch < 3; ch++) begin
      ca[ch]   = mc[ch*5 +: 5];
      cb[ch]   = opnd[ch*5 +: 5];
      sum[ch]  = {1'b0, ca[ch]} + {1'b0, cb[ch]};
      diff[ch] = (ca[ch] > cb[ch]) ? (ca[ch] - cb[ch]) : 5'd0;
      if (cfg_i.subtract) begin
        math_res[ch*5 +: 5] = halve ? {1'b0, diff[ch][4:1]} : diff[ch];
      end else if (halve) begin
        math_res[ch*5 +: 5] = sum[ch][5:1];
      end else begin
        math_res[ch*5 +: 5] = sum[ch][5] ? 5'h1f : sum[ch][4:0];
      end
    end
    color_o = math_on ? math_res : mc;
  end

endmodule

/* design/scanline_priority_compositor.sv */
// ----------------------------------------------------------------------------
// scanline_priority_compositor
// Main/sub line stores with priority plotting, color windows and color math.
// ----------------------------------------------------------------------------
// Throughput: one command per cycle while in_stall_o is low (memory read
// on transfer, write back from stage 1 the cycle after). An emit passes
// stage 1, then the output buffer; it waits in stage 1, stalling the input,
// until the buffer can take its results, e.g. right behind a hires pair.
// Reset clears configuration and handshake state; the line memory is not
// cleared and holds unknown data until init, plot or set-window writes.
// ----------------------------------------------------------------------------
module scanline_priority_compositor #(
  parameter int unsigned LINE_WIDTH = 256
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // configuration write port
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_index_i,
  input  logic [14:0] cfg_wdata_i,
  // command channel
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [2:0]  cmd_i,
  input  logic [7:0]  column_i,
  input  logic [2:0]  source_i,
  input  logic [3:0]  priority_req_i,
  input  logic [14:0] color_i,
  input  logic        window_main_i,
  input  logic        window_sub_i,
  // pixel channel
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [14:0] pixel_color_o,
  output logic [3:0]  pixel_brightness_o,
  output logic        last_o
);

  // Only 256 columns are addressable; wider lines need no more storage.
  localparam int unsigned Depth = (LINE_WIDTH < 256) ? LINE_WIDTH : 256;
  localparam int unsigned AddrW = $clog2(Depth);
  localparam logic [9:0]  LineW = 10'(LINE_WIDTH);

  typedef struct packed {
    logic [2:0]  cmd;
    logic [7:0]  column;
    logic [2:0]  src;
    logic [3:0]  prio;
    logic [14:0] color;
    logic        win_main;
    logic        win_sub;
    logic        in_line;
  } item_t;

  // --------------------------------------------------------------------------
  // Configuration registers
  // --------------------------------------------------------------------------
  spc_pkg::cfg_t cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        spc_pkg::CFG_MATH_MASK:   cfg_q.math_mask   <= cfg_wdata_i[6:0];
        spc_pkg::CFG_USE_SUB:     cfg_q.use_sub     <= cfg_wdata_i[0];
        spc_pkg::CFG_SUBTRACT:    cfg_q.subtract    <= cfg_wdata_i[0];
        spc_pkg::CFG_HALVE:       cfg_q.halve_en    <= cfg_wdata_i[0];
        spc_pkg::CFG_FIXED_COLOR: cfg_q.fixed_color <= cfg_wdata_i;
        spc_pkg::CFG_BRIGHTNESS:  cfg_q.brightness  <= cfg_wdata_i[3:0];
        spc_pkg::CFG_HIRES:       cfg_q.hires       <= cfg_wdata_i[0];
        spc_pkg::CFG_DISP_OFF:    cfg_q.disp_off    <= cfg_wdata_i[0];
        default: ;
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // Handshake
  // --------------------------------------------------------------------------
  logic       in_xfer;
  logic       out_xfer;
  logic       s1_valid_q;
  item_t      s1_q;
  logic       s1_emit;
  logic       s1_go;
  logic [1:0] cnt_q;

  assign out_xfer = out_valid_o & ~out_stall_i;
  assign s1_emit  = s1_valid_q && (s1_q.cmd == spc_pkg::CMD_EMIT);
  // an emit may leave stage 1 once the output buffer can take the new pair
  assign s1_go    = !s1_emit || (cnt_q == 2'd0) || ((cnt_q == 2'd1) && out_xfer);
  assign in_stall_o = s1_valid_q & ~s1_go;
  assign in_xfer    = in_valid_i & ~in_stall_o;

  // --------------------------------------------------------------------------
  // Stage 1: command register, issued with the memory read
  // --------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_xfer) begin
      s1_valid_q <= 1'b1;
    end else if (s1_go) begin
      s1_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      s1_q.cmd      <= cmd_i;
      s1_q.column   <= column_i;
      s1_q.src      <= source_i;
      s1_q.prio     <= priority_req_i;
      s1_q.color    <= color_i;
      s1_q.win_main <= window_main_i;
      s1_q.win_sub  <= window_sub_i;
      s1_q.in_line  <= {2'b00, column_i} < LineW;
    end
  end

  // --------------------------------------------------------------------------
  // Line memory: read on transfer, modify and write back from stage 1.
  // A back-to-back access to the column being written takes the new word.
  // --------------------------------------------------------------------------
  spc_pkg::word_t mem [Depth];
  spc_pkg::word_t rd_q;
  spc_pkg::word_t wr_word;
  logic           wr_en;
  logic           fwd;

  always_comb begin
    wr_word = rd_q;
    wr_en   = s1_valid_q && s1_q.in_line &&
              (s1_q.cmd inside {spc_pkg::CMD_INIT, spc_pkg::CMD_PLOT_MAIN,
                                spc_pkg::CMD_PLOT_SUB, spc_pkg::CMD_SET_WINDOW});
    case (s1_q.cmd)
      spc_pkg::CMD_INIT: begin
        wr_word.main_px = '{src: spc_pkg::SRC_BACKDROP, prio: 4'd0, color: s1_q.color};
        wr_word.sub_px  = '{src: spc_pkg::SRC_BACKDROP, prio: 4'd0,
                            color: cfg_q.hires ? s1_q.color : cfg_q.fixed_color};
      end
      spc_pkg::CMD_PLOT_MAIN: begin
        if (s1_q.prio > rd_q.main_px.prio) begin
          wr_word.main_px = '{src: s1_q.src, prio: s1_q.prio, color: s1_q.color};
        end
      end
      spc_pkg::CMD_PLOT_SUB: begin
        if (s1_q.prio > rd_q.sub_px.prio) begin
          wr_word.sub_px = '{src: s1_q.src, prio: s1_q.prio, color: s1_q.color};
        end
      end
      spc_pkg::CMD_SET_WINDOW: begin
        wr_word.win_main = s1_q.win_main;
        wr_word.win_sub  = s1_q.win_sub;
      end
      default: ;
    endcase
  end

  assign fwd = wr_en && (s1_q.column == column_i);

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[s1_q.column[AddrW-1:0]] <= wr_word;
    end
    if (in_xfer) begin
      rd_q <= fwd ? wr_word : mem[column_i[AddrW-1:0]];
    end
  end

  // --------------------------------------------------------------------------
  // Color math, normal and hires-swapped
  // --------------------------------------------------------------------------
  logic [14:0] color_norm;
  logic [14:0] color_swap;

  spc_composite u_comp_norm (
    .cfg_i      (cfg_q),
    .main_i     (rd_q.main_px),
    .sub_i      (rd_q.sub_px),
    .win_main_i (rd_q.win_main),
    .win_sub_i  (rd_q.win_sub),
    .color_o    (color_norm)
  );

  spc_composite u_comp_swap (
    .cfg_i      (cfg_q),
    .main_i     (rd_q.sub_px),
    .sub_i      (rd_q.main_px),
    .win_main_i (rd_q.win_main),
    .win_sub_i  (rd_q.win_sub),
    .color_o    (color_swap)
  );

  // --------------------------------------------------------------------------
  // Output buffer: up to two results, drained in order through res0_q
  // --------------------------------------------------------------------------
  spc_pkg::result_t res_norm;
  spc_pkg::result_t res_swap;
  spc_pkg::result_t res0_q;
  spc_pkg::result_t res1_q;
  logic             blank;
  logic             load;

  always_comb begin
    // display off or a column past the line end gives black at brightness 0
    blank    = cfg_q.disp_off || !s1_q.in_line;
    res_norm = blank ? spc_pkg::result_t'{color: 15'd0, brightness: 4'd0, last: 1'b1}
                     : spc_pkg::result_t'{color: color_norm, brightness: cfg_q.brightness,
                                          last: 1'b1};
    res_swap = blank ? spc_pkg::result_t'{color: 15'd0, brightness: 4'd0, last: 1'b0}
                     : spc_pkg::result_t'{color: color_swap, brightness: cfg_q.brightness,
                                          last: 1'b0};
  end

  assign load = s1_emit && s1_go;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= 2'd0;
    end else if (load) begin
      cnt_q <= cfg_q.hires ? 2'd2 : 2'd1;
    end else if (out_xfer) begin
      cnt_q <= cnt_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      res0_q <= cfg_q.hires ? res_swap : res_norm;
      res1_q <= res_norm;
    end else if (out_xfer) begin
      res0_q <= res1_q;
    end
  end

  assign out_valid_o        = (cnt_q != 2'd0);
  assign pixel_color_o      = res0_q.color;
  assign pixel_brightness_o = res0_q.brightness;
  assign last_o             = res0_q.last;

endmodule

/* design/spc_checker.sv */
// ----------------------------------------------------------------------------
// spc_checker
// Port-level checks for the scanline priority compositor, bound to the top.
// ----------------------------------------------------------------------------
module spc_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_stall_o,
  input logic        out_valid_o,
  input logic        out_stall_i,
  input logic [14:0] pixel_color_o,
  input logic [3:0]  pixel_brightness_o,
  input logic        last_o
);

  logic in_xfer;
  assign in_xfer = in_valid_i & ~in_stall_o;

  // a held result does not change
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o &&
      $stable(pixel_color_o) && $stable(pixel_brightness_o) && $stable(last_o))
    else $error("output changed while stalled");

  // the second result of a hires pair follows right behind the first
  a_pair_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !last_o && !out_stall_i |=> out_valid_o)
    else $error("hires pair split");

  // input only waits on a pending output
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o |-> !in_stall_o)
    else $error("input stalled with empty output");

  // with nothing accepted and nothing pending, no result appears
  a_no_phantom: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!in_xfer && !out_valid_o) ##1 (!in_xfer && !out_valid_o) |=> !out_valid_o)
    else $error("result without command");

endmodule

bind scanline_priority_compositor spc_checker u_spc_checker (.*);
